FILE: rtl/sapt_pkg.sv
package sapt_pkg;

  localparam int SAPT_MAX_POINTS_DEF = 16;

  localparam int CMD_W   = 2;
  localparam int IDX_W   = 4;
  localparam int ANGLE_W = 16;
  localparam int PULSE_W = 12;
  localparam int CNT_W   = 5;

  // Interpolation datapath: (a*d) is 16x12, then 2*prod + den, divided by 2*den.
  localparam int PROD_W    = ANGLE_W + PULSE_W;
  localparam int DIV_NUM_W = PROD_W + 2;
  localparam int DIV_DEN_W = ANGLE_W + 1;

  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_COMMIT  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CONVERT = 2'd2;

  localparam logic [PULSE_W-1:0] CENTER_DEF = 12'd1231;
  localparam logic [PULSE_W-1:0] PULSE_MIN  = 12'd500;
  localparam logic [PULSE_W-1:0] PULSE_MAX  = 12'd2500;
  localparam logic [CNT_W-1:0]   COUNT_MIN  = 5'd3;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic [PULSE_W-1:0]        pulse;
  } point_t;

endpackage

FILE: rtl/sapt_if.sv
interface sapt_in_if;
  import sapt_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic [IDX_W-1:0]          point_index;
  logic signed [ANGLE_W-1:0] angle;
  logic [PULSE_W-1:0]        pulse_in;
  logic [CNT_W-1:0]          count_in;

  modport source (output valid, cmd, point_index, angle, pulse_in, count_in, input ready);
  modport sink   (input valid, cmd, point_index, angle, pulse_in, count_in, output ready);
endinterface

interface sapt_out_if;
  import sapt_pkg::*;

  logic               valid;
  logic               ready;
  logic [PULSE_W-1:0] pulse_width;
  logic               ok;
  logic               calibrated;

  modport source (output valid, pulse_width, ok, calibrated, input ready);
  modport sink   (input valid, pulse_width, ok, calibrated, output ready);
endinterface

FILE: rtl/servo_angle_to_pulse_table.sv
// Sequence: load and unused requests go straight to the result; commit reads the first two points,
// then checks up to count_in entries; convert ends early when clamped or uncalibrated, else walks
// the point memory one entry per cycle to the segment, then multiplies and runs the serial divider.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset (synchronous, rst_n low): table entries read as zero, no table in force,
// center pulse 1231 us.
module servo_angle_to_pulse_table #(
  parameter int MAX_POINTS = sapt_pkg::SAPT_MAX_POINTS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  sapt_in_if.sink   in_chan,
  sapt_out_if.source out_chan
);
  import sapt_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DONE   = 4'd1;
  localparam logic [3:0] ST_C_P0   = 4'd2;
  localparam logic [3:0] ST_C_P1   = 4'd3;
  localparam logic [3:0] ST_C_WALK = 4'd4;
  localparam logic [3:0] ST_V_E0   = 4'd5;
  localparam logic [3:0] ST_V_EN   = 4'd6;
  localparam logic [3:0] ST_V_WALK = 4'd7;
  localparam logic [3:0] ST_V_MUL  = 4'd8;
  localparam logic [3:0] ST_V_DIV  = 4'd9;
  localparam logic [3:0] ST_V_WAIT = 4'd10;

  logic [3:0]                state_r, state_nxt;
  logic                      valid_r, valid_nxt;
  logic [CW-1:0]             n_r, n_nxt;
  logic [PULSE_W-1:0]        center_r, center_nxt;
  logic                      out_valid_r, out_valid_nxt;

  logic signed [ANGLE_W-1:0] x_r, x_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic [CW-1:0]             k_r, k_nxt;
  point_t                    prev_r, prev_nxt;
  logic [PULSE_W-1:0]        first_p_r, first_p_nxt;
  logic                      rising_r, rising_nxt;
  logic                      found_r, found_nxt;
  logic [ANGLE_W-1:0]        m_r, m_nxt;
  logic [PULSE_W-1:0]        dd_r, dd_nxt;
  logic [PULSE_W-1:0]        base_r, base_nxt;
  logic [ANGLE_W-1:0]        den_r, den_nxt;
  logic [PROD_W-1:0]         prod_r, prod_nxt;
  logic [PULSE_W-1:0]        res_pulse_r, res_pulse_nxt;
  logic                      res_ok_r, res_ok_nxt;
  logic [PULSE_W-1:0]        out_pulse_r, out_pulse_nxt;
  logic                      out_ok_r, out_ok_nxt;
  logic                      out_cal_r, out_cal_nxt;

  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  point_t                    mem_wdata;
  logic [AW-1:0]             rd_addr;
  point_t                    cur;

  logic                      div_start;
  logic                      div_done;
  logic [DIV_NUM_W-1:0]      div_num;
  logic [DIV_DEN_W-1:0]      div_den;
  logic [DIV_NUM_W-1:0]      div_quot;

  logic                      idx_ok;
  logic                      cnt_ok;
  logic [CW-1:0]             k_inc;
  logic [CW-1:0]             n_last;
  logic [CW-1:0]             count_last;
  logic                      walk_fail;
  logic                      seg_hit;
  logic                      seg_rising;
  logic [ANGLE_W:0]          den_seg;
  logic [ANGLE_W:0]          d_a0x;
  logic [ANGLE_W:0]          d_xa1;

  sapt_point_mem #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_addr),
    .rdata (cur)
  );

  sapt_div #(
    .NW (DIV_NUM_W),
    .DW (DIV_DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign in_chan.ready = (state_r == ST_IDLE);

  assign mem_waddr = AW'(in_chan.point_index);
  assign mem_wdata = '{angle: in_chan.angle, pulse: in_chan.pulse_in};

  assign idx_ok = 32'(in_chan.point_index) < 32'(MAX_POINTS);
  assign cnt_ok = (in_chan.count_in >= COUNT_MIN) &&
                  (32'(in_chan.count_in) <= 32'(MAX_POINTS));

  assign k_inc      = k_r + CW'(1);
  assign n_last     = n_r - CW'(1);
  assign count_last = count_r - CW'(1);

  assign walk_fail = (cur.pulse < PULSE_MIN) || (cur.pulse > PULSE_MAX) ||
                     ((k_r != '0) && ((prev_r.angle <= cur.angle) ||
                      (rising_r ? (prev_r.pulse >= cur.pulse) : (prev_r.pulse <= cur.pulse)))) ||
                     ((cur.angle == '0) && found_r);

  // Segment from the previous point (a0, p0) to the current one (a1, p1).
  assign seg_hit    = (k_r != '0) && (x_r <= prev_r.angle) && (x_r >= cur.angle);
  assign den_seg    = {prev_r.angle[ANGLE_W-1], prev_r.angle} - {cur.angle[ANGLE_W-1], cur.angle};
  assign d_a0x      = {prev_r.angle[ANGLE_W-1], prev_r.angle} - {x_r[ANGLE_W-1], x_r};
  assign d_xa1      = {x_r[ANGLE_W-1], x_r} - {cur.angle[ANGLE_W-1], cur.angle};
  assign seg_rising = cur.pulse >= prev_r.pulse;

  // A falling segment is interpolated from its far end so that every term stays
  // non-negative; the floor of the rounded quotient is the same.
  assign div_num = {1'b0, prod_r, 1'b0} + DIV_NUM_W'(den_r);
  assign div_den = {den_r, 1'b0};

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    n_nxt         = n_r;
    center_nxt    = center_r;
    x_nxt         = x_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    prev_nxt      = prev_r;
    first_p_nxt   = first_p_r;
    rising_nxt    = rising_r;
    found_nxt     = found_r;
    m_nxt         = m_r;
    dd_nxt        = dd_r;
    base_nxt      = base_r;
    den_nxt       = den_r;
    prod_nxt      = prod_r;
    res_pulse_nxt = res_pulse_r;
    res_ok_nxt    = res_ok_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_pulse_nxt = out_pulse_r;
    out_ok_nxt    = out_ok_r;
    out_cal_nxt   = out_cal_r;
    mem_we        = 1'b0;
    rd_addr       = '0;
    div_start     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          x_nxt         = in_chan.angle;
          res_pulse_nxt = center_r;
          res_ok_nxt    = 1'b0;
          state_nxt     = ST_DONE;
          case (in_chan.cmd)
            CMD_LOAD: begin
              mem_we     = idx_ok;
              res_ok_nxt = idx_ok;
            end
            CMD_COMMIT: begin
              valid_nxt = 1'b0;
              n_nxt     = '0;
              count_nxt = CW'(in_chan.count_in);
              if (cnt_ok) begin
                state_nxt = ST_C_P0;
              end
            end
            CMD_CONVERT: begin
              if (!valid_r) begin
                res_ok_nxt = (in_chan.angle == '0);
              end else begin
                state_nxt = ST_V_E0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ST_C_P0: begin
        first_p_nxt = cur.pulse;
        rd_addr     = AW'(1);
        state_nxt   = ST_C_P1;
      end

      ST_C_P1: begin
        if (cur.pulse == first_p_r) begin
          state_nxt = ST_DONE;
        end else begin
          rising_nxt = cur.pulse > first_p_r;
          found_nxt  = 1'b0;
          k_nxt      = '0;
          state_nxt  = ST_C_WALK;
        end
      end

      ST_C_WALK: begin
        if (walk_fail) begin
          res_pulse_nxt = center_r;
          state_nxt     = ST_DONE;
        end else begin
          if (cur.angle == '0) begin
            center_nxt = cur.pulse;
            found_nxt  = 1'b1;
          end
          prev_nxt = cur;
          if (k_r == count_last) begin
            if (found_r || (cur.angle == '0)) begin
              valid_nxt  = 1'b1;
              n_nxt      = count_r;
              res_ok_nxt = 1'b1;
            end
            res_pulse_nxt = center_nxt;
            state_nxt     = ST_DONE;
          end else begin
            rd_addr = k_inc[AW-1:0];
            k_nxt   = k_inc;
          end
        end
      end

      ST_V_E0: begin
        if (x_r >= cur.angle) begin
          res_pulse_nxt = cur.pulse;
          res_ok_nxt    = 1'b1;
          state_nxt     = ST_DONE;
        end else begin
          rd_addr   = n_last[AW-1:0];
          state_nxt = ST_V_EN;
        end
      end

      ST_V_EN: begin
        if (x_r <= cur.angle) begin
          res_pulse_nxt = cur.pulse;
          res_ok_nxt    = 1'b1;
          state_nxt     = ST_DONE;
        end else begin
          k_nxt     = '0;
          state_nxt = ST_V_WALK;
        end
      end

      ST_V_WALK: begin
        if (seg_hit) begin
          if (den_seg == '0) begin
            res_pulse_nxt = prev_r.pulse;
            res_ok_nxt    = 1'b1;
            state_nxt     = ST_DONE;
          end else begin
            den_nxt = den_seg[ANGLE_W-1:0];
            if (seg_rising) begin
              m_nxt    = d_a0x[ANGLE_W-1:0];
              dd_nxt   = cur.pulse - prev_r.pulse;
              base_nxt = prev_r.pulse;
            end else begin
              m_nxt    = d_xa1[ANGLE_W-1:0];
              dd_nxt   = prev_r.pulse - cur.pulse;
              base_nxt = cur.pulse;
            end
            state_nxt = ST_V_MUL;
          end
        end else if (k_r == n_last) begin
          res_pulse_nxt = center_r;
          state_nxt     = ST_DONE;
        end else begin
          prev_nxt = cur;
          rd_addr  = k_inc[AW-1:0];
          k_nxt    = k_inc;
        end
      end

      ST_V_MUL: begin
        prod_nxt  = PROD_W'(m_r) * PROD_W'(dd_r);
        state_nxt = ST_V_DIV;
      end

      ST_V_DIV: begin
        div_start = 1'b1;
        state_nxt = ST_V_WAIT;
      end

      ST_V_WAIT: begin
        if (div_done) begin
          res_pulse_nxt = base_r + div_quot[PULSE_W-1:0];
          res_ok_nxt    = 1'b1;
          state_nxt     = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_pulse_nxt = res_pulse_r;
          out_ok_nxt    = res_ok_r;
          out_cal_nxt   = valid_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= 1'b0;
      n_r         <= '0;
      center_r    <= CENTER_DEF;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      n_r         <= n_nxt;
      center_r    <= center_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    count_r     <= count_nxt;
    k_r         <= k_nxt;
    prev_r      <= prev_nxt;
    first_p_r   <= first_p_nxt;
    rising_r    <= rising_nxt;
    found_r     <= found_nxt;
    m_r         <= m_nxt;
    dd_r        <= dd_nxt;
    base_r      <= base_nxt;
    den_r       <= den_nxt;
    prod_r      <= prod_nxt;
    res_pulse_r <= res_pulse_nxt;
    res_ok_r    <= res_ok_nxt;
    out_pulse_r <= out_pulse_nxt;
    out_ok_r    <= out_ok_nxt;
    out_cal_r   <= out_cal_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.pulse_width = out_pulse_r;
  assign out_chan.ok          = out_ok_r;
  assign out_chan.calibrated  = out_cal_r;

endmodule

FILE: rtl/sapt_point_mem.sv
module sapt_point_mem #(
  parameter int DEPTH = sapt_pkg::SAPT_MAX_POINTS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  sapt_pkg::point_t wdata,
  input  logic [AW-1:0]    raddr,
  output sapt_pkg::point_t rdata
);
  import sapt_pkg::*;

  point_t           mem_r [DEPTH];
  point_t           rd_r;
  logic [DEPTH-1:0] vld_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_r <= mem_r[raddr];
  end

  // Entries never written read as zero, which is the table's reset value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      rd_vld_r <= vld_r[raddr];
    end
  end

  assign rdata = rd_vld_r ? rd_r : '0;

endmodule

FILE: rtl/sapt_div.sv
module sapt_div #(
  parameter int NW = sapt_pkg::DIV_NUM_W,
  parameter int DW = sapt_pkg::DIV_DEN_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot
);
  import sapt_pkg::*;

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] q_r, q_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;
  logic          ge;

  // Restoring division, one quotient bit per cycle, numerator shifted out MSB first.
  assign shifted = {rem_r, q_r[NW-1]};
  assign ge      = shifted >= {1'b0, den_r};
  assign diff    = shifted - {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      q_nxt    = num;
      den_nxt  = den;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DW-1:0] : shifted[DW-1:0];
      q_nxt   = {q_r[NW-2:0], ge};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

FILE: rtl/sapt_checker.sv
module sapt_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [sapt_pkg::PULSE_W-1:0] out_pulse_width,
  input logic                         out_ok,
  input logic                         out_calibrated
);
  import sapt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pulse_width) && $stable(out_ok) &&
                                $stable(out_calibrated))
    else $error("result changed while stalled");

  // Only one request is in flight: the port closes right after it takes one.
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  // A failed request reports the center pulse, which only ever holds a checked value.
  a_fail_center: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> (out_pulse_width >= PULSE_MIN) && (out_pulse_width <= PULSE_MAX))
    else $error("failure pulse outside the legal range");

endmodule

bind servo_angle_to_pulse_table sapt_checker u_sapt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_pulse_width (out_chan.pulse_width),
  .out_ok          (out_chan.ok),
  .out_calibrated  (out_chan.calibrated)
);

FILE: tb/sv/servo_pulse_checker.sv
`timescale 1ns / 100ps

module servo_pulse_checker (
  input  logic clk,
  input  logic rst_n,
  sapt_in_if   in_mon,
  sapt_out_if  out_mon,
  output int   mismatches,
  output int   outstanding
);
  import sapt_pkg::*;

  localparam int NPTS = SAPT_MAX_POINTS_DEF;

  typedef struct packed {
    logic [PULSE_W-1:0] pulse_width;
    logic               ok;
    logic               calibrated;
  } pulse_result_t;

  // Shadow copy of the calibration table and its status.
  logic signed [ANGLE_W-1:0] pt_angle [NPTS];
  logic [PULSE_W-1:0]        pt_pulse [NPTS];
  int unsigned               pts_used;
  logic                      tbl_valid;
  logic [PULSE_W-1:0]        ctr_pulse;

  pulse_result_t pending_pulses [$];

  function automatic logic commit_points(input int unsigned count);
    logic rising;
    logic seen_zero;
    seen_zero = 1'b0;
    tbl_valid = 1'b0;
    pts_used  = 0;
    if (count < COUNT_MIN || count > NPTS) return 1'b0;
    if (pt_pulse[1] == pt_pulse[0]) return 1'b0;
    rising = pt_pulse[1] > pt_pulse[0];
    for (int i = 0; i < count; i++) begin
      if (pt_pulse[i] < PULSE_MIN || pt_pulse[i] > PULSE_MAX) return 1'b0;
      if (i > 0) begin
        if (pt_angle[i-1] <= pt_angle[i]) return 1'b0;
        if (rising ? (pt_pulse[i-1] >= pt_pulse[i]) : (pt_pulse[i-1] <= pt_pulse[i]))
          return 1'b0;
      end
      // A zero point moves the center even if a later point fails.
      if (pt_angle[i] == 0) begin
        if (seen_zero) return 1'b0;
        ctr_pulse = pt_pulse[i];
        seen_zero = 1'b1;
      end
    end
    if (!seen_zero) return 1'b0;
    pts_used  = count;
    tbl_valid = 1'b1;
    return 1'b1;
  endfunction

  function automatic logic convert_angle(input logic signed [ANGLE_W-1:0] x,
                                         output logic [PULSE_W-1:0] pulse);
    longint a0, a1, p0, p1, den, num, q, xl;
    pulse = ctr_pulse;
    xl    = x;
    if (!tbl_valid) return (x == 0);
    if (pts_used < 2 || pts_used > NPTS) return 1'b0;
    if (x >= pt_angle[0]) begin
      pulse = pt_pulse[0];
      return 1'b1;
    end
    if (x <= pt_angle[pts_used-1]) begin
      pulse = pt_pulse[pts_used-1];
      return 1'b1;
    end
    for (int i = 0; i + 1 < pts_used; i++) begin
      a0 = pt_angle[i];
      a1 = pt_angle[i+1];
      if (xl <= a0 && xl >= a1) begin
        p0  = pt_pulse[i];
        p1  = pt_pulse[i+1];
        den = a0 - a1;
        if (den <= 0) begin
          pulse = PULSE_W'(p0);
          return 1'b1;
        end
        // Round half up: floor of the quotient with the half folded in.
        num = 2 * (a0 - xl) * (p1 - p0) + den;
        den = 2 * den;
        q   = num / den;
        if ((num % den) != 0 && num < 0) q = q - 1;
        pulse = PULSE_W'(p0 + q);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic pulse_result_t predict_pulse(input logic [CMD_W-1:0] cmd,
                                                  input logic [IDX_W-1:0] idx,
                                                  input logic signed [ANGLE_W-1:0] ang,
                                                  input logic [PULSE_W-1:0] pin,
                                                  input logic [CNT_W-1:0] cnt);
    pulse_result_t r;
    logic [PULSE_W-1:0] conv;
    r.ok = 1'b0;
    conv = ctr_pulse;
    case (cmd)
      CMD_LOAD: begin
        if (idx < NPTS) begin
          pt_angle[idx] = ang;
          pt_pulse[idx] = pin;
          r.ok = 1'b1;
        end
      end
      CMD_COMMIT:  r.ok = commit_points(cnt);
      CMD_CONVERT: r.ok = convert_angle(ang, conv);
      default: ;
    endcase
    r.pulse_width = (cmd == CMD_CONVERT && r.ok) ? conv : ctr_pulse;
    r.calibrated  = tbl_valid;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    pulse_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < NPTS; i++) begin
        pt_angle[i] = '0;
        pt_pulse[i] = '0;
      end
      pts_used  = 0;
      tbl_valid = 1'b0;
      ctr_pulse = CENTER_DEF;
      pending_pulses.delete();
      mismatches = 0;
    end else begin
      // The request is recorded before the result is taken, which keeps the
      // order right even if both land on the same edge.
      if (in_mon.valid && in_mon.ready)
        pending_pulses.push_back(predict_pulse(in_mon.cmd, in_mon.point_index, in_mon.angle,
                                               in_mon.pulse_in, in_mon.count_in));
      if (out_mon.valid && out_mon.ready) begin
        if (pending_pulses.size() == 0) begin
          report_mismatch("result with no request outstanding", out_mon.pulse_width, 0);
        end else begin
          want = pending_pulses.pop_front();
          if (out_mon.pulse_width !== want.pulse_width)
            report_mismatch("pulse_width", out_mon.pulse_width, want.pulse_width);
          if (out_mon.ok !== want.ok)
            report_mismatch("ok", out_mon.ok, want.ok);
          if (out_mon.calibrated !== want.calibrated)
            report_mismatch("calibrated", out_mon.calibrated, want.calibrated);
        end
      end
    end
    outstanding = pending_pulses.size();
  end

endmodule

FILE: tb/sv/servo_angle_to_pulse_table_test.sv
`timescale 1ns / 100ps

module servo_angle_to_pulse_table_test;
  import sapt_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int ITEMS      = 550;
  localparam int LONG_HOLD  = 400;
  localparam int END_WAIT   = 60;
  localparam int LIMIT      = 500000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   outstanding;
  int   cycle_count;
  int   items_sent;
  int   burst_left;
  int   hold_requests;
  int   hold_served;

  sapt_in_if  in_bus ();
  sapt_out_if out_bus ();

  servo_angle_to_pulse_table i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  servo_pulse_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_bus),
    .out_mon     (out_bus),
    .mismatches  (fail_count),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Sends one request; the sender idles between bursts of random length.
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                              input logic signed [ANGLE_W-1:0] ang,
                              input logic [PULSE_W-1:0] pin, input logic [CNT_W-1:0] cnt);
    if (burst_left == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    in_bus.valid       <= 1'b1;
    in_bus.cmd         <= cmd;
    in_bus.point_index <= idx;
    in_bus.angle       <= ang;
    in_bus.pulse_in    <= pin;
    in_bus.count_in    <= cnt;
    do @(posedge clk); while (!in_bus.ready);
    burst_left--;
    items_sent++;
    if (items_sent == 150 || items_sent == 400) hold_requests++;
  endtask

  task automatic load_point(input int idx, input int ang, input int pin);
    send_request(CMD_LOAD, IDX_W'(idx), ANGLE_W'(ang), PULSE_W'(pin), CNT_W'($urandom));
  endtask

  task automatic commit_request(input int cnt);
    send_request(CMD_COMMIT, IDX_W'($urandom), ANGLE_W'($urandom), PULSE_W'($urandom),
                 CNT_W'(cnt));
  endtask

  task automatic convert_request(input int ang);
    send_request(CMD_CONVERT, IDX_W'($urandom), ANGLE_W'(ang), PULSE_W'($urandom),
                 CNT_W'($urandom));
  endtask

  task automatic drain_results();
    in_bus.valid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Builds a table with one zero angle, usually valid and sometimes with
  // one flaw, loads and commits it, then converts angles against it.
  task automatic run_table_sequence();
    int angl [16];
    int puls [16];
    int n, z, k, j, m, lo, hi, room, tmp, flaw, cnt, x;
    bit tight, down;
    n     = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 16) : $urandom_range(3, 6);
    z     = $urandom_range(0, n - 1);
    tight = ($urandom_range(0, 2) == 0);
    down  = 1'($urandom_range(0, 1));
    angl[z] = 0;
    for (k = z - 1; k >= 0; k--) begin
      room = (32767 - angl[k+1]) / (k + 1);
      if (tight && room > 40) room = 40;
      angl[k] = angl[k+1] + $urandom_range(1, room);
    end
    if (z > 0 && $urandom_range(0, 3) == 0) angl[0] = 32767;
    for (k = z + 1; k < n; k++) begin
      room = (angl[k-1] + 32768) / (n - k);
      if (tight && room > 40) room = 40;
      angl[k] = angl[k-1] - $urandom_range(1, room);
    end
    if (z < n - 1 && $urandom_range(0, 3) == 0) angl[n-1] = -32768;
    lo = ($urandom_range(0, 3) == 0) ? 500 : $urandom_range(500, 900);
    for (k = 0; k < n; k++) begin
      hi = 2500 - (n - 1 - k);
      puls[k] = $urandom_range(lo, lo + (hi - lo) / (n - k));
      if (k == n - 1 && $urandom_range(0, 3) == 0) puls[k] = 2500;
      lo = puls[k] + 1;
    end
    if (down) begin
      for (k = 0; k < n / 2; k++) begin
        tmp = puls[k];
        puls[k] = puls[n-1-k];
        puls[n-1-k] = tmp;
      end
    end
    cnt  = n;
    flaw = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
    k    = $urandom_range(1, n - 1);
    case (flaw)
      1: cnt = $urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(17, 31);
      2: puls[1] = puls[0];
      3: begin
        case ($urandom_range(0, 3))
          0: puls[k-1] = 0;
          1: puls[k-1] = 499;
          2: puls[k-1] = 2501;
          default: puls[k-1] = 4095;
        endcase
      end
      4: angl[k] = angl[k-1];
      5: begin
        tmp = puls[k];
        puls[k] = puls[k-1];
        puls[k-1] = tmp;
      end
      6: angl[(k == z) ? (z + 1) % n : k] = 0;
      7: angl[z] = (z == 0) ? 1 : -1;
      default: ;
    endcase
    if ($urandom_range(0, 1)) begin
      for (k = 0; k < n; k++) load_point(k, angl[k], puls[k]);
    end else begin
      for (k = n - 1; k >= 0; k--) load_point(k, angl[k], puls[k]);
    end
    commit_request(cnt);
    m = $urandom_range(3, 10);
    for (j = 0; j < m; j++) begin
      // Editing a point of the table in force keeps it calibrated.
      if ($urandom_range(0, 9) == 0)
        load_point($urandom_range(0, n - 1), $urandom_range(0, 65535), $urandom_range(0, 4095));
      k = $urandom_range(0, n - 1);
      case ($urandom_range(0, 5))
        0: x = $urandom_range(0, 65535);
        1: x = angl[k];
        2: x = angl[k] + $urandom_range(0, 4) - 2;
        3: begin
          if (k == n - 1) k = n - 2;
          lo = angl[k+1];
          hi = angl[k];
          x  = (hi > lo) ? lo + $urandom_range(0, hi - lo) : hi;
        end
        4: x = 0;
        default: x = $urandom_range(0, 1) ? 32767 : -32768;
      endcase
      convert_request(x);
    end
  endtask

  initial begin : stimulus
    rst_n              <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.cmd         <= CMD_LOAD;
    in_bus.point_index <= '0;
    in_bus.angle       <= '0;
    in_bus.pulse_in    <= '0;
    in_bus.count_in    <= '0;
    items_sent    = 0;
    burst_left    = 0;
    hold_requests = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Uncalibrated: only a zero angle converts.
    convert_request(0);
    convert_request(100);
    send_request(CMD_SPARE, '1, '1, '1, '1);
    commit_request(0);
    commit_request(31);
    // Full-range table, pulses rising with angle.
    load_point(0, 32767, 2500);
    load_point(1, 5000, 1800);
    load_point(2, 0, 1500);
    load_point(3, -5000, 1000);
    load_point(4, -32768, 500);
    commit_request(5);
    convert_request(32767);
    convert_request(-32768);
    convert_request(2500);
    convert_request(-1);
    convert_request(1234);
    send_request(CMD_SPARE, '0, '0, '0, '0);
    // Load while calibrated, then a commit that fails past the zero point.
    load_point(15, -1, 4095);
    commit_request(16);
    convert_request(0);
    convert_request(7);
    drain_results();

    while (items_sent < ITEMS) begin
      if ($urandom_range(0, 9) < 8) begin
        run_table_sequence();
      end else begin
        repeat ($urandom_range(1, 4))
          send_request(CMD_W'($urandom), IDX_W'($urandom), ANGLE_W'($urandom),
                       PULSE_W'($urandom), CNT_W'($urandom));
      end
      if ($urandom_range(0, 7) == 0) drain_results();
    end

    drain_results();
    repeat (END_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : receiver
    int stretch, mode, c;
    hold_served = 0;
    out_bus.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      // A long hold-off lets the block fill up and stall the sender.
      if (hold_served != hold_requests) begin
        hold_served++;
        out_bus.ready <= 1'b0;
        for (c = 0; c < LONG_HOLD; c++) @(posedge clk);
      end
      stretch = $urandom_range(10, 60);
      mode    = $urandom_range(0, 2);
      for (c = 0; c < stretch; c++) begin
        case (mode)
          0: out_bus.ready <= 1'b1;
          1: out_bus.ready <= 1'($urandom_range(0, 1));
          default: out_bus.ready <= (c % 4 == 3);
        endcase
        @(posedge clk);
      end
    end
  end

endmodule

FILE: servo_angle_to_pulse_table.f
rtl/sapt_pkg.sv
rtl/sapt_if.sv
rtl/sapt_point_mem.sv
rtl/sapt_div.sv
rtl/servo_angle_to_pulse_table.sv
rtl/sapt_checker.sv
tb/sv/servo_pulse_checker.sv
tb/sv/servo_angle_to_pulse_table_test.sv
